FILE: design/frame_chunk_packetizer_defines.svh
// assertion macros shared by the frame chunk packetizer files
// no dependencies; ASSERT_OFF empties every macro
`ifndef FRAME_CHUNK_PACKETIZER_DEFINES_SVH
`define FRAME_CHUNK_PACKETIZER_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FCP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fcp assertion failed");
// next-cycle implication
`define FCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fcp assertion failed");
`else
`define FCP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FCP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/fcp_pkg.sv
// types, constants and control program of the frame chunk packetizer
// no dependencies; imported by fcp_seq and frame_chunk_packetizer
package fcp_pkg;

    // field widths
    localparam int LENGTH_BITS = 24;
    localparam int PAYLOAD_W   = 16;
    localparam int LEVEL_W     = 32;
    localparam int TIME_W      = 32;
    localparam int ID_W        = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // header layout
    localparam int HDR_BYTES = 17;
    localparam int HIDX_W    = $clog2(HDR_BYTES);
    localparam int DIV_NUM_W = LENGTH_BITS + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WATERMARK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOPPED        = 2'd2;

    // configuration reset values
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RST    = 16'd16384;
    localparam logic [LEVEL_W-1:0]   HIGH_WATERMARK_RST = 32'd1048576;

    // keyframe byte of the header
    localparam logic [7:0] KEY_BYTE_SET = 8'h01;
    localparam logic [7:0] KEY_BYTE_CLR = 8'h00;

    // input word
    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   first_of_frame;
        logic [LENGTH_BITS-1:0] frame_length;
        logic                   keyframe_flag;
        logic [LEVEL_W-1:0]     buffered_level;
        logic [TIME_W-1:0]      send_time_ms;
        logic                   channel_open;
    } t_in_item;

    // output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       chunk_first;
        logic       chunk_last;
        logic       run_last;
    } t_out_item;

    // program steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FRAME   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_CHECK   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CHUNK   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_HEADER  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_PAYLOAD = 3'd5;

    // hold conditions
    localparam int HOLD_W = 2;
    localparam logic [HOLD_W-1:0] HOLD_NONE = 2'd0;
    localparam logic [HOLD_W-1:0] HOLD_IN   = 2'd1;
    localparam logic [HOLD_W-1:0] HOLD_OUT  = 2'd2;
    localparam logic [HOLD_W-1:0] HOLD_DIV  = 2'd3;

    // branch conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] COND_SKIP     = 3'd2;
    localparam logic [COND_W-1:0] COND_MID      = 3'd3;
    localparam logic [COND_W-1:0] COND_HDR_MORE = 3'd4;

    // control word
    typedef struct packed {
        logic              accept;
        logic              frame_upd;
        logic              psize_ld;
        logic              emit_hdr;
        logic              emit_data;
        logic [HOLD_W-1:0] hold_on;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_ctl;

    // status fed back to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic div_busy;
        logic skip;
        logic mid_chunk;
        logic hdr_more;
    } t_seq_stat;

    // control store
    function automatic t_ctl prog_word(input logic [STEP_W-1:0] pc);
        t_ctl w;
        w = '0;
        unique case (pc)
            STEP_IDLE: begin
                w.accept  = 1'b1;
                w.hold_on = HOLD_IN;
                w.cond    = COND_NEVER;
            end
            STEP_FRAME: begin
                w.frame_upd = 1'b1;
                w.cond      = COND_NEVER;
            end
            STEP_CHECK: begin
                w.hold_on = HOLD_DIV;
                w.cond    = COND_SKIP;
                w.target  = STEP_IDLE;
            end
            STEP_CHUNK: begin
                w.psize_ld = 1'b1;
                w.cond     = COND_MID;
                w.target   = STEP_PAYLOAD;
            end
            STEP_HEADER: begin
                w.emit_hdr = 1'b1;
                w.hold_on  = HOLD_OUT;
                w.cond     = COND_HDR_MORE;
                w.target   = STEP_HEADER;
            end
            STEP_PAYLOAD: begin
                w.emit_data = 1'b1;
                w.hold_on   = HOLD_OUT;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: design/fcp_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies; used by frame_chunk_packetizer for the chunk count
module fcp_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [NUM_W-1:0] n_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] n_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] n_den;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // trial subtraction of the divisor
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        if (i_start) begin
            n_cnt = CNT_W'(NUM_W);
            n_quo = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;

endmodule

FILE: design/fcp_seq.sv
// step counter and control store of the packetizer sequencer
// depends on fcp_pkg
module fcp_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcp_pkg::t_seq_stat i_stat,
    output fcp_pkg::t_ctl     o_ctl,
    output logic              o_go
);

    import fcp_pkg::*;

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctl              ctl;
    logic              hold;
    logic              taken;

    assign ctl = prog_word(r_pc);

    // hold decode
    always_comb begin
        unique case (ctl.hold_on)
            HOLD_NONE: hold = 1'b0;
            HOLD_IN:   hold = !i_stat.in_valid;
            HOLD_OUT:  hold = i_stat.out_busy;
            HOLD_DIV:  hold = i_stat.div_busy;
            default:   hold = 1'b0;
        endcase
    end

    // branch decode
    always_comb begin
        unique case (ctl.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_SKIP:     taken = i_stat.skip;
            COND_MID:      taken = i_stat.mid_chunk;
            COND_HDR_MORE: taken = i_stat.hdr_more;
            default:       taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (hold) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = ctl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl = ctl;
    assign o_go  = !hold;

endmodule

FILE: design/frame_chunk_packetizer.sv
// Frame chunk packetizer: one input word is taken per program run and gives 0, 1 or 18 words.
// A chunk start emits 17 header words ahead of the data word; a first byte that is kept
// starts the bit-serial chunk-count divider, which the check step waits for.
// Mid-chunk, a word passes the idle, frame, check, chunk and payload steps to the output.
// Synchronous active-low reset: configuration to defaults; ids and frame state to zero,
// except r_in and r_psize. Depends on fcp_pkg, fcp_seq, fcp_div and frame_chunk_packetizer_defines.svh
`include "frame_chunk_packetizer_defines.svh"

module frame_chunk_packetizer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  fcp_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output fcp_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [fcp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fcp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import fcp_pkg::*;

    // configuration
    logic [PAYLOAD_W-1:0]   r_max_payload;
    logic [LEVEL_W-1:0]     r_high_wm;
    logic                   r_stopped;

    // frame state
    t_in_item               r_in;
    logic [ID_W-1:0]        r_next_id;
    logic [ID_W-1:0]        n_next_id;
    logic [ID_W-1:0]        r_cur_id;
    logic [ID_W-1:0]        n_cur_id;
    logic                   r_dropping;
    logic                   n_dropping;
    logic [LENGTH_BITS-1:0] r_frame_bytes;
    logic [LENGTH_BITS-1:0] n_frame_bytes;
    logic [LENGTH_BITS-1:0] r_offset;
    logic [LENGTH_BITS-1:0] n_offset;
    logic [PAYLOAD_W-1:0]   r_pos;
    logic [PAYLOAD_W-1:0]   n_pos;
    logic [PAYLOAD_W-1:0]   r_num;
    logic [PAYLOAD_W-1:0]   n_num;
    logic                   r_key;
    logic                   n_key;
    logic [TIME_W-1:0]      r_time;
    logic [TIME_W-1:0]      n_time;
    logic [PAYLOAD_W-1:0]   r_psize;
    logic [PAYLOAD_W-1:0]   n_psize;
    logic [HIDX_W-1:0]      r_hidx;
    logic [HIDX_W-1:0]      n_hidx;

    // output register
    logic                   r_out_valid;
    logic                   n_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    // sequencer and divider
    t_ctl                   ctl;
    t_seq_stat              stat;
    logic                   go;
    logic                   div_start;
    logic                   div_busy;
    logic [DIV_NUM_W-1:0]   div_num;
    logic [DIV_NUM_W-1:0]   div_quo;

    // combinational helpers
    logic [PAYLOAD_W-1:0]   mp;
    logic                   drop;
    logic [LENGTH_BITS-1:0] rem;
    logic                   last;
    logic                   out_load;
    logic [HIDX_W-1:0]      hdr_sel;
    logic [HDR_BYTES-1:0][7:0] hdr_vec;

    fcp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_go    (go)
    );

    fcp_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (PAYLOAD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (mp),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RST;
            r_high_wm     <= HIGH_WATERMARK_RST;
            r_stopped     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_PAYLOAD:    r_max_payload <= i_cfg_wdata[PAYLOAD_W-1:0];
                CFG_HIGH_WATERMARK: r_high_wm     <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_STOPPED:        r_stopped     <= i_cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // effective payload limit, zero counts as one
    assign mp = (r_max_payload == '0) ? PAYLOAD_W'(1) : r_max_payload;

    // drop decision on a first byte
    assign drop = r_stopped || !r_in.channel_open || (r_in.frame_length == '0)
                  || (!r_in.keyframe_flag && (r_in.buffered_level > r_high_wm));

    // ceiling of frame length over payload limit
    assign div_num = DIV_NUM_W'(r_in.frame_length) + DIV_NUM_W'(mp) - DIV_NUM_W'(1);

    // bytes left in the frame and end-of-chunk test
    assign rem  = r_frame_bytes - r_offset;
    assign last = (({1'b0, r_pos} + 1'b1) >= {1'b0, mp})
                  || (({1'b0, r_offset} + 1'b1) >= {1'b0, r_frame_bytes});

    // header bytes, first byte in the top element
    assign hdr_vec = {r_cur_id, r_num, div_quo[PAYLOAD_W-1:0],
                      (r_key ? KEY_BYTE_SET : KEY_BYTE_CLR),
                      16'd0, r_psize, r_time};
    assign hdr_sel = HIDX_W'(HDR_BYTES - 1) - r_hidx;

    // sequencer status
    always_comb begin
        stat.in_valid  = i_in_valid;
        stat.out_busy  = r_out_valid && !i_out_ready;
        stat.div_busy  = div_busy;
        stat.skip      = r_dropping || (r_offset >= r_frame_bytes);
        stat.mid_chunk = r_pos != '0;
        stat.hdr_more  = r_hidx != HIDX_W'(HDR_BYTES - 1);
    end

    assign o_in_ready = ctl.accept;
    assign out_load   = go && (ctl.emit_hdr || ctl.emit_data);

    // frame and chunk bookkeeping
    always_comb begin
        n_next_id     = r_next_id;
        n_cur_id      = r_cur_id;
        n_dropping    = r_dropping;
        n_frame_bytes = r_frame_bytes;
        n_offset      = r_offset;
        n_pos         = r_pos;
        n_num         = r_num;
        n_key         = r_key;
        n_time        = r_time;
        n_psize       = r_psize;
        n_hidx        = r_hidx;
        div_start     = 1'b0;
        if (go && ctl.frame_upd && r_in.first_of_frame) begin
            n_frame_bytes = r_in.frame_length;
            n_offset      = '0;
            n_pos         = '0;
            n_num         = '0;
            n_dropping    = drop;
            if (!drop) begin
                n_key     = r_in.keyframe_flag;
                n_time    = r_in.send_time_ms;
                n_cur_id  = r_next_id;
                n_next_id = r_next_id + 1'b1;
                div_start = 1'b1;
            end
        end
        if (go && ctl.psize_ld) begin
            n_psize = (rem < LENGTH_BITS'(mp)) ? rem[PAYLOAD_W-1:0] : mp;
        end
        if (go && ctl.emit_hdr) begin
            n_hidx = stat.hdr_more ? r_hidx + 1'b1 : '0;
        end
        if (go && ctl.emit_data) begin
            n_offset = r_offset + 1'b1;
            if (last) begin
                n_pos = '0;
                n_num = r_num + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id     <= '0;
            r_cur_id      <= '0;
            r_dropping    <= 1'b0;
            r_frame_bytes <= '0;
            r_offset      <= '0;
            r_pos         <= '0;
            r_num         <= '0;
            r_key         <= 1'b0;
            r_time        <= '0;
            r_hidx        <= '0;
        end else begin
            r_next_id     <= n_next_id;
            r_cur_id      <= n_cur_id;
            r_dropping    <= n_dropping;
            r_frame_bytes <= n_frame_bytes;
            r_offset      <= n_offset;
            r_pos         <= n_pos;
            r_num         <= n_num;
            r_key         <= n_key;
            r_time        <= n_time;
            r_hidx        <= n_hidx;
        end
    end

    // input word and payload size capture
    always_ff @(posedge i_clk) begin
        if (go && ctl.accept) begin
            r_in <= i_in;
        end
        r_psize <= n_psize;
    end

    // output register, refilled as the word is taken
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (out_load) begin
            n_out_valid = 1'b1;
            if (ctl.emit_hdr) begin
                n_out.out_byte    = hdr_vec[hdr_sel];
                n_out.chunk_first = r_hidx == '0;
                n_out.chunk_last  = 1'b0;
                n_out.run_last    = 1'b0;
            end else begin
                n_out.out_byte    = r_in.data_byte;
                n_out.chunk_first = 1'b0;
                n_out.chunk_last  = last;
                n_out.run_last    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `FCP_ASSERT_IMPL(a_hdr_at_chunk_start, i_clk, i_rst_n, out_load && ctl.emit_hdr, r_pos == '0)
    `FCP_ASSERT_IMPL(a_hdr_after_div, i_clk, i_rst_n, out_load && ctl.emit_hdr, !div_busy)
    `FCP_ASSERT_IMPL(a_data_in_frame, i_clk, i_rst_n, out_load && ctl.emit_data, !r_dropping && (r_offset < r_frame_bytes))
    `FCP_ASSERT_NEXT(a_one_word_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

FILE: tb/sv/tb_frame_chunk_packetizer.sv
// self-checking testbench for frame_chunk_packetizer: directed frames, then random traffic
// a scoreboard class predicts every header and payload word; depends on fcp_pkg and the rtl
module tb_frame_chunk_packetizer;
    import fcp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int DRAIN_CYCLES  = 80;
    localparam int RANDOM_ITEMS  = 336;
    localparam int SEGMENTS      = 9;
    localparam int HALT_SEGMENT  = 4;
    localparam int HALT_WORDS    = 40;

    // predicts the chunk words of each accepted input word and checks them in order
    class chunk_scoreboard;
        bit [15:0] payload_cap;
        bit [31:0] level_limit;
        bit        halted;
        bit [31:0] id_next;
        bit [31:0] id_cur;
        bit [31:0] stamp;
        bit        skipping;
        bit        key_flag;
        bit [LENGTH_BITS-1:0] len_frame;
        bit [LENGTH_BITS-1:0] pos_frame;
        bit [15:0] pos_chunk;
        bit [15:0] idx_chunk;
        bit [15:0] n_chunks;
        t_out_item chunk_words_due[$];
        int        errors;

        function new();
            payload_cap = MAX_PAYLOAD_RST;
            level_limit = HIGH_WATERMARK_RST;
            halted      = 1'b0;
            id_next     = '0;
            id_cur      = '0;
            stamp       = '0;
            skipping    = 1'b0;
            key_flag    = 1'b0;
            len_frame   = '0;
            pos_frame   = '0;
            pos_chunk   = '0;
            idx_chunk   = '0;
            n_chunks    = '0;
            errors      = 0;
        endfunction

        function void set_config(input bit [CFG_IDX_W-1:0] idx, input bit [31:0] data);
            case (idx)
                CFG_MAX_PAYLOAD:    payload_cap = data[15:0];
                CFG_HIGH_WATERMARK: level_limit = data;
                CFG_STOPPED:        halted = data[0];
                default: ;
            endcase
        endfunction

        // returns how many output words this input word causes
        function int note_byte(input t_in_item w);
            int unsigned cap;
            int unsigned rest;
            int unsigned psize;
            longint unsigned total;
            bit [135:0] hdr;
            bit fin;
            int n;
            int i;
            t_out_item o;
            cap = (payload_cap == 0) ? 1 : payload_cap;
            n = 0;
            // frame start: drop decision, chunk count, new id
            if (w.first_of_frame) begin
                skipping = halted || !w.channel_open || (w.frame_length == 0)
                           || (!w.keyframe_flag && (w.buffered_level > level_limit));
                len_frame = w.frame_length;
                pos_frame = '0;
                pos_chunk = '0;
                idx_chunk = '0;
                if (!skipping) begin
                    total = 64'(w.frame_length);
                    total = (total + cap - 1) / cap;
                    n_chunks = total[15:0];
                    key_flag = w.keyframe_flag;
                    stamp    = w.send_time_ms;
                    id_cur   = id_next;
                    id_next  = id_next + 1;
                end
            end
            if (skipping || pos_frame >= len_frame)
                return 0;
            // header ahead of the first payload byte of a chunk
            if (pos_chunk == 0) begin
                rest  = len_frame - pos_frame;
                psize = (rest < cap) ? rest : cap;
                hdr = {id_cur, idx_chunk, n_chunks, key_flag ? KEY_BYTE_SET : KEY_BYTE_CLR,
                       psize, stamp};
                for (i = 0; i < HDR_BYTES; i++) begin
                    o.out_byte    = hdr[135 - 8*i -: 8];
                    o.chunk_first = (i == 0);
                    o.chunk_last  = 1'b0;
                    o.run_last    = 1'b0;
                    chunk_words_due.push_back(o);
                    n++;
                end
            end
            // payload byte
            fin = (pos_chunk + 32'd1 >= cap) || (pos_frame + 32'd1 >= len_frame);
            o.out_byte    = w.data_byte;
            o.chunk_first = 1'b0;
            o.chunk_last  = fin;
            o.run_last    = 1'b1;
            chunk_words_due.push_back(o);
            n++;
            pos_frame = pos_frame + 1'b1;
            if (fin) begin
                pos_chunk = '0;
                idx_chunk = idx_chunk + 1'b1;
            end else begin
                pos_chunk = pos_chunk + 1'b1;
            end
            return n;
        endfunction

        task report_mismatch(input string field, input int got, input int want);
            $display("mismatch on %s: got %0h, expected %0h", field, got, want);
            errors++;
        endtask

        task check_word(input t_out_item got);
            t_out_item want;
            if (chunk_words_due.size() == 0) begin
                report_mismatch("word with nothing expected", got, 0);
                return;
            end
            want = chunk_words_due.pop_front();
            if (got.out_byte != want.out_byte)
                report_mismatch("out_byte", got.out_byte, want.out_byte);
            if (got.chunk_first != want.chunk_first)
                report_mismatch("chunk_first", got.chunk_first, want.chunk_first);
            if (got.chunk_last != want.chunk_last)
                report_mismatch("chunk_last", got.chunk_last, want.chunk_last);
            if (got.run_last != want.run_last)
                report_mismatch("run_last", got.run_last, want.run_last);
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_item;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0]          cfg_wdata = '0;

    chunk_scoreboard sb;
    int send_idle = 29;
    int recv_idle = 49;
    int words_sent = 0;
    int cycles = 0;

    frame_chunk_packetizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // clock
    always #(CLK_HALF) clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

    // every accepted output word goes to the scoreboard
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(out_item);
    end

    // first word of a frame
    function automatic t_in_item head_word(input logic [LENGTH_BITS-1:0] len, input logic key,
                                           input logic [31:0] level, input logic [31:0] ts,
                                           input logic open, input logic [7:0] data);
        t_in_item w;
        w.data_byte      = data;
        w.first_of_frame = 1'b1;
        w.frame_length   = len;
        w.keyframe_flag  = key;
        w.buffered_level = level;
        w.send_time_ms   = ts;
        w.channel_open   = open;
        return w;
    endfunction

    // body byte, the frame-start fields carry noise
    function automatic t_in_item body_word();
        t_in_item w;
        w.data_byte      = 8'($urandom);
        w.first_of_frame = 1'b0;
        w.frame_length   = LENGTH_BITS'($urandom);
        w.keyframe_flag  = 1'($urandom);
        w.buffered_level = $urandom;
        w.send_time_ms   = $urandom;
        w.channel_open   = 1'($urandom);
        return w;
    endfunction

    // level at, just above, or anywhere around the watermark
    function automatic logic [31:0] pick_level();
        case ($urandom_range(2))
            0:       return sb.level_limit;
            1:       return sb.level_limit + 1;
            default: return $urandom;
        endcase
    endfunction

    // one input word through the handshake, random gaps ahead of it
    task automatic send_word(input t_in_item w);
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_item  = w;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        void'(sb.note_byte(w));
        words_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_body(input int count);
        repeat (count) send_word(body_word());
    endtask

    // all expected words out, then room for words that give no output
    task automatic wait_idle();
        while (sb.chunk_words_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = data;
        sb.set_config(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // random traffic under one setting: mostly whole frames, some noise and broken frames
    task automatic run_segment(input int quota);
        int start;
        int r;
        int len;
        int cut;
        int cap;
        int max_len;
        start   = words_sent;
        cap     = (sb.payload_cap == 0) ? 1 : sb.payload_cap;
        max_len = (cap * 3 < 40) ? cap * 3 : 40;
        while (words_sent - start < quota) begin
            r = $urandom_range(99);
            if (r < 8) begin
                // stray byte
                send_word(body_word());
            end else if (r < 12) begin
                // empty frame
                send_word(head_word('0, 1'($urandom), pick_level(), $urandom, 1'b1,
                                    8'($urandom)));
            end else if (r < 18) begin
                // huge frame, abandoned after a few bytes
                send_word(head_word(LENGTH_BITS'($urandom), 1'($urandom), pick_level(),
                                    $urandom, 1'b1, 8'($urandom)));
                send_body($urandom_range(0, 4));
            end else begin
                len = $urandom_range(1, max_len);
                cut = ($urandom_range(9) == 0) ? $urandom_range(1, len) : len;
                send_word(head_word(LENGTH_BITS'(len), 1'($urandom), pick_level(), $urandom,
                                    $urandom_range(11) != 0, 8'($urandom)));
                send_body(cut - 1);
            end
        end
    endtask

    initial begin
        t_in_item w;
        int seg;
        int mp;
        logic [31:0] wm;
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults first
        // stray byte before any frame
        send_word(body_word());
        // empty frame, no id taken
        send_word(head_word('0, 1'b1, 32'd0, 32'd0, 1'b1, 8'h00));
        // two-byte keyframe with extreme bytes and stamp
        send_word(head_word(LENGTH_BITS'(2), 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'h00));
        w = body_word();
        w.data_byte = 8'hFF;
        send_word(w);
        // byte after the frame is complete
        send_word(body_word());
        // non-keyframe just above the watermark is dropped with its body
        send_word(head_word(LENGTH_BITS'(3), 1'b0, HIGH_WATERMARK_RST + 1, 32'h1234_5678, 1'b1,
                            8'h55));
        send_word(body_word());
        // level equal to the watermark passes
        send_word(head_word(LENGTH_BITS'(1), 1'b0, HIGH_WATERMARK_RST, 32'd0, 1'b1, 8'hAA));
        // closed channel
        send_word(head_word(LENGTH_BITS'(1), 1'b1, 32'd0, 32'd0, 1'b0, 8'h11));

        // stopped drops everything
        wait_idle();
        cfg_write(CFG_STOPPED, 32'd1);
        send_word(head_word(LENGTH_BITS'(1), 1'b1, 32'd0, 32'd0, 1'b1, 8'h22));

        // zero payload limit acts as one byte per chunk, watermark at zero
        wait_idle();
        cfg_write(CFG_STOPPED, 32'd0);
        cfg_write(CFG_MAX_PAYLOAD, 32'd0);
        cfg_write(CFG_HIGH_WATERMARK, 32'd0);
        send_word(head_word(LENGTH_BITS'(2), 1'b0, 32'd0, $urandom, 1'b1, 8'($urandom)));
        send_body(1);
        send_word(head_word(LENGTH_BITS'(1), 1'b0, 32'd1, $urandom, 1'b1, 8'($urandom)));
        // longest frame: chunk count wraps to 16 bits
        send_word(head_word('1, 1'b1, $urandom, 32'h8000_0001, 1'b1, 8'($urandom)));
        send_body(1);
        // new frame abandons the old one, then the limit changes part way through
        send_word(head_word(LENGTH_BITS'(5), 1'b1, $urandom, $urandom, 1'b1, 8'($urandom)));
        send_body(1);
        wait_idle();
        cfg_write(CFG_MAX_PAYLOAD, 32'd2);
        send_body(3);

        // widest limit and watermark, upper write bits ignored
        wait_idle();
        cfg_write(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
        cfg_write(CFG_HIGH_WATERMARK, 32'hFFFF_FFFF);
        send_word(head_word('1, 1'b0, 32'hFFFF_FFFF, $urandom, 1'b1, 8'($urandom)));
        send_body(1);
        send_word(head_word(LENGTH_BITS'(1), 1'b1, $urandom, $urandom, 1'b1, 8'($urandom)));

        // random segments, each under a fresh setting
        for (seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 3) begin
                send_idle = 29;
                recv_idle = 49;
            end else if (seg < 6) begin
                send_idle = 49;
                recv_idle = 29;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            case ($urandom_range(9))
                0:       mp = 0;
                1:       mp = 16'hFFFF;
                2:       mp = 256;
                3:       mp = $urandom_range(0, 16'hFFFF);
                default: mp = $urandom_range(1, 12);
            endcase
            case ($urandom_range(3))
                0:       wm = 32'd0;
                1:       wm = 32'hFFFF_FFFF;
                default: wm = $urandom;
            endcase
            wait_idle();
            cfg_write(CFG_MAX_PAYLOAD, 32'(mp));
            cfg_write(CFG_HIGH_WATERMARK, wm);
            cfg_write(CFG_STOPPED, (seg == HALT_SEGMENT) ? 32'd1 : 32'd0);
            if (seg == HALT_SEGMENT)
                run_segment(HALT_WORDS);
            else
                run_segment(RANDOM_ITEMS / (SEGMENTS - 1));
        end

        // drain
        while (sb.chunk_words_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.chunk_words_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
